/* sv/smed_pkg.sv */
// Shared constants and the control bundle of the running median filter.
// No dependencies; imported by smed_cell, smed_ctrl and sliding_window_median.
package smed_pkg;

	localparam int SAMPLE_W       = 32;
	localparam int OUT_W          = 33;
	localparam int CFG_W          = 7;
	localparam int WINDOW_MAX_DEF = 64;
	localparam int WS_RESET       = 3;

	// Per-cycle commands from the sequencer to the cell row
	typedef struct packed {
		logic accept;   // shift a new sample in and reload the probes
		logic count;    // probes compare against the resident samples
		logic rotate;   // probes move one cell toward cell 0
		logic pick;     // capture the middle ranks as they pass cell 0
		logic emit;     // load the output register
	} smed_ctl_t;

endpackage

/* sv/smed_cell.sv */
// One cell of the median row: a resident sample plus a circulating probe
// that gathers its rank. Depends on smed_pkg.
module smed_cell #(
	parameter int W   = smed_pkg::WINDOW_MAX_DEF,
	parameter int IDX = 0,
	localparam int IW = (W > 1) ? $clog2(W) : 1
) (
	input  logic                                  clk,
	input  smed_pkg::smed_ctl_t                   ctl,
	input  logic signed [smed_pkg::SAMPLE_W-1:0]  stat_in,
	input  logic signed [smed_pkg::SAMPLE_W-1:0]  nb_val,
	input  logic [IW-1:0]                         nb_idx,
	input  logic [IW-1:0]                         nb_rank,
	output logic signed [smed_pkg::SAMPLE_W-1:0]  stat,
	output logic signed [smed_pkg::SAMPLE_W-1:0]  pval,
	output logic [IW-1:0]                         pidx,
	output logic [IW-1:0]                         rank_next
);
	import smed_pkg::*;

	logic signed [SAMPLE_W-1:0] stat_q;
	logic signed [SAMPLE_W-1:0] pval_q;
	logic [IW-1:0]              pidx_q;
	logic [IW-1:0]              prank_q;
	logic                       below;

	// Resident sample ranks below the probe; equal values break by age
	always_comb begin
		below = (stat_q < pval_q) || ((stat_q == pval_q) && (IW'(IDX) < pidx_q));
		rank_next = prank_q + IW'(ctl.count && below);
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			stat_q  <= stat_in;
			pval_q  <= stat_in;
			pidx_q  <= IW'(IDX);
			prank_q <= '0;
		end else if (ctl.rotate) begin
			pval_q  <= nb_val;
			pidx_q  <= nb_idx;
			prank_q <= nb_rank;
		end
	end

	assign stat = stat_q;
	assign pval = pval_q;
	assign pidx = pidx_q;

endmodule

/* sv/smed_ctrl.sv */
// Sequencer of the median filter: window size register, fill count,
// count and pick passes, output load. Depends on smed_pkg.
module smed_ctrl #(
	parameter int W = smed_pkg::WINDOW_MAX_DEF,
	localparam int IW = (W > 1) ? $clog2(W) : 1,
	localparam int KW = $clog2(W + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [smed_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                         in_valid,
	input  logic                         start_of_sequence,
	input  logic                         out_free,
	output logic                         in_stall,
	output smed_pkg::smed_ctl_t          ctl,
	output logic [KW-1:0]                k,
	output logic [IW-1:0]                lo_rank,
	output logic [IW-1:0]                hi_rank
);
	import smed_pkg::*;

	localparam int CW = (CFG_W > KW) ? CFG_W : KW;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_COUNT = 2'd1;
	localparam logic [1:0] S_PICK  = 2'd2;
	localparam logic [1:0] S_EMIT  = 2'd3;

	logic [1:0]       state_q;
	logic [CFG_W-1:0] ws_q;
	logic [KW-1:0]    fill_q;
	logic [KW-1:0]    k_q;
	logic [IW-1:0]    cnt_q;
	logic [KW-1:0]    k_cur;
	logic [KW-1:0]    fill_next;
	logic [KW-1:0]    half;
	logic             accept;
	logic             go;
	logic             last;

	always_comb begin
		if (ws_q == '0) begin
			k_cur = KW'(1);
		end else if (CW'(ws_q) > CW'(W)) begin
			k_cur = KW'(W);
		end else begin
			k_cur = KW'(ws_q);
		end
		if (start_of_sequence) begin
			fill_next = KW'(1);
		end else if (fill_q == KW'(W)) begin
			fill_next = fill_q;
		end else begin
			fill_next = fill_q + KW'(1);
		end
		accept = in_valid && !in_stall;
		go     = fill_next >= k_cur;
		last   = KW'(cnt_q) == (k_q - KW'(1));
		half   = k_q >> 1;
		hi_rank = IW'(half);
		lo_rank = k_q[0] ? IW'(half) : IW'(half - KW'(1));
	end

	assign in_stall   = state_q != S_IDLE;
	assign k          = k_q;
	assign ctl.accept = accept;
	assign ctl.count  = state_q == S_COUNT;
	assign ctl.rotate = (state_q == S_COUNT) || (state_q == S_PICK);
	assign ctl.pick   = state_q == S_PICK;
	assign ctl.emit   = (state_q == S_EMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ws_q    <= CFG_W'(WS_RESET);
			fill_q  <= '0;
			k_q     <= KW'(1);
			cnt_q   <= '0;
		end else begin
			if (cfg_we) begin
				ws_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						fill_q <= fill_next;
						k_q    <= k_cur;
						cnt_q  <= '0;
						if (go) begin
							state_q <= S_COUNT;
						end
					end
				end
				S_COUNT: begin
					if (last) begin
						cnt_q   <= '0;
						state_q <= S_PICK;
					end else begin
						cnt_q <= cnt_q + IW'(1);
					end
				end
				S_PICK: begin
					if (last) begin
						cnt_q   <= '0;
						state_q <= S_EMIT;
					end else begin
						cnt_q <= cnt_q + IW'(1);
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_cnt_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COUNT || state_q == S_PICK) |-> (KW'(cnt_q) < k_q))
		else $error("pass counter ran past the window");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= KW'(W))
		else $error("fill count above window capacity");

	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(k_q != '0) && (k_q <= KW'(W)))
		else $error("effective window size out of range");

	a_full_starts_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && go) |=> (state_q == S_COUNT && cnt_q == '0))
		else $error("full window did not start the count pass");

	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !go) |=> (state_q == S_IDLE))
		else $error("short window left the sequencer busy");

endmodule

/* sv/sliding_window_median.sv */
// Top level of the running median filter: cell row, sequencer, middle-rank
// capture and output register. Depends on smed_pkg, smed_cell, smed_ctrl.
//
// Input channel: sample and start_of_sequence, taken when in_valid is high
// and in_stall is low. start_of_sequence empties the window first.
// Output channel: median_twice (twice the window median), taken when
// out_valid is high and out_stall is low. cfg_we writes window_size from
// cfg_wdata; write it only while the block is idle.
// An item whose window is not yet full produces no result. Otherwise, with
// k the effective window size, the probe ring of the first k cells rotates
// through a count pass to rank every sample and a pick pass to move the two
// middle ranks past cell 0, and then the result is loaded into the output
// register. in_stall stays high until that load, so the block takes no new
// sample while it is still working on the last one.
// While the receiver stalls, the finished result holds in the output
// register and the block waits before loading the next one. Reset empties
// the window, clears out_valid and sets window_size to 3.
module sliding_window_median #(
	parameter int WINDOW_MAX = smed_pkg::WINDOW_MAX_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [smed_pkg::CFG_W-1:0]           cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [smed_pkg::SAMPLE_W-1:0] sample,
	input  logic                                 start_of_sequence,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [smed_pkg::OUT_W-1:0]    median_twice
);
	import smed_pkg::*;

	localparam int W  = WINDOW_MAX;
	localparam int IW = (W > 1) ? $clog2(W) : 1;
	localparam int KW = $clog2(W + 1);

	smed_ctl_t                  ctl;
	logic [KW-1:0]              k;
	logic [IW-1:0]              lo_rank;
	logic [IW-1:0]              hi_rank;
	logic                       out_free;
	logic signed [SAMPLE_W-1:0] stat [W];
	logic signed [SAMPLE_W-1:0] pval [W];
	logic [IW-1:0]              pidx [W];
	logic [IW-1:0]              rnk  [W];
	logic signed [SAMPLE_W-1:0] lo_q;
	logic signed [SAMPLE_W-1:0] hi_q;
	logic signed [OUT_W-1:0]    median_q;
	logic                       out_valid_q;

	assign out_free = !out_valid_q || !out_stall;

	smed_ctrl #(.W(W)) u_ctrl (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.in_valid          (in_valid),
		.start_of_sequence (start_of_sequence),
		.out_free          (out_free),
		.in_stall          (in_stall),
		.ctl               (ctl),
		.k                 (k),
		.lo_rank           (lo_rank),
		.hi_rank           (hi_rank)
	);

	for (genvar i = 0; i < W; i++) begin : g_cell
		localparam int NB = (i == W - 1) ? 0 : i + 1;
		logic                       wrap;
		logic signed [SAMPLE_W-1:0] s_in;

		// The last cell of the active window closes the ring back to cell 0
		assign wrap = k == KW'(i + 1);
		if (i == 0) begin : g_head
			assign s_in = sample;
		end else begin : g_body
			assign s_in = stat[i-1];
		end

		smed_cell #(.W(W), .IDX(i)) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.stat_in   (s_in),
			.nb_val    (wrap ? pval[0] : pval[NB]),
			.nb_idx    (wrap ? pidx[0] : pidx[NB]),
			.nb_rank   (wrap ? rnk[0] : rnk[NB]),
			.stat      (stat[i]),
			.pval      (pval[i]),
			.pidx      (pidx[i]),
			.rank_next (rnk[i])
		);
	end

	// Grab the middle ranks as they pass cell 0
	always_ff @(posedge clk) begin
		if (ctl.pick && (rnk[0] == lo_rank)) begin
			lo_q <= pval[0];
		end
		if (ctl.pick && (rnk[0] == hi_rank)) begin
			hi_q <= pval[0];
		end
		if (ctl.emit) begin
			median_q <= OUT_W'(lo_q) + OUT_W'(hi_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign median_twice = median_q;

endmodule

/* dv/smed_check_pkg.sv */
`timescale 1ns / 1ps
// Scoreboard for the running median filter: tracks the sample ring and window size,
// predicts twice the window median for each accepted request that fills its window and checks results in order.
// Depends on smed_pkg for widths and the window depth.
package smed_check_pkg;

	import smed_pkg::*;

	class median_scoreboard;

		logic signed [SAMPLE_W-1:0] ring [WINDOW_MAX_DEF];
		int unsigned held;
		int unsigned next_slot;
		logic [CFG_W-1:0] window_size;
		logic signed [OUT_W-1:0] pending_medians [$];
		int unsigned mismatches;

		function new();
			held = 0;
			next_slot = 0;
			window_size = CFG_W'(WS_RESET);
			mismatches = 0;
		endfunction

		function void set_window(logic [CFG_W-1:0] value);
			window_size = value;
		endfunction

		// zero acts as one, anything above the ring depth as the full ring
		function int unsigned span();
			if (window_size == 0)
				return 1;
			if (window_size > WINDOW_MAX_DEF)
				return WINDOW_MAX_DEF;
			return window_size;
		endfunction

		function void note_request(logic signed [SAMPLE_W-1:0] value, logic restart);
			logic signed [SAMPLE_W-1:0] win [WINDOW_MAX_DEF];
			logic signed [SAMPLE_W-1:0] key;
			int unsigned k;
			int i;
			int j;
			longint total;
			if (restart) begin
				held = 0;
				next_slot = 0;
			end
			ring[next_slot] = value;
			next_slot = (next_slot + 1) % WINDOW_MAX_DEF;
			if (held < WINDOW_MAX_DEF)
				held++;
			k = span();
			if (held < k)
				return;
			// insertion sort of the newest k samples, newest first
			for (i = 0; i < k; i++) begin
				key = ring[(next_slot + WINDOW_MAX_DEF - 1 - i) % WINDOW_MAX_DEF];
				j = i;
				while (j > 0 && win[j-1] > key) begin
					win[j] = win[j-1];
					j--;
				end
				win[j] = key;
			end
			if (k % 2 == 1)
				total = 2 * longint'(win[k/2]);
			else
				total = longint'(win[k/2-1]) + longint'(win[k/2]);
			pending_medians.push_back(OUT_W'(total));
		endfunction

		function void check_result(logic signed [OUT_W-1:0] got);
			logic signed [OUT_W-1:0] want;
			if (pending_medians.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("median mismatch: got %0d with none expected", got);
			end else begin
				want = pending_medians[0];
				pending_medians.delete(0);
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("median mismatch: expected %0d got %0d", want, got);
				end
			end
		endfunction

		function int unsigned pending();
			return pending_medians.size();
		endfunction

		function bit failed();
			return mismatches != 0;
		endfunction

	endclass

endpackage

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Top-level testbench for sliding_window_median: drives requests and window sizes,
// stalls the result side at random and checks every median. Depends on smed_pkg,
// smed_check_pkg and the RTL.
module tb_top;

	import smed_pkg::*;
	import smed_check_pkg::*;

	localparam int HALF_PERIOD  = 4;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 2 * WINDOW_MAX_DEF + 8;
	localparam int NUM_PHASES   = 24;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_W-1:0]           cfg_wdata;
	logic                       in_valid;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       start_of_sequence;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [OUT_W-1:0]    median_twice;

	bit                         steady = 1'b0;
	int unsigned                cycle_count = 0;
	logic signed [SAMPLE_W-1:0] last_sample = '0;
	median_scoreboard           medians;

	always #HALF_PERIOD clk = ~clk;

	sliding_window_median uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.sample            (sample),
		.start_of_sequence (start_of_sequence),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.median_twice      (median_twice)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic send_request(logic signed [SAMPLE_W-1:0] value, logic restart);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid          <= 1'b1;
		sample            <= value;
		start_of_sequence <= restart;
		do @(posedge clk); while (in_stall);
		medians.note_request(value, restart);
		last_sample = value;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5, 6:    return int'($urandom_range(0, 20)) - 10;
			7:          return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
			8:          return $urandom_range(0, 1) ? SAMPLE_MAX - $urandom_range(0, 3)
			                                        : SAMPLE_MIN + $urandom_range(0, 3);
			default:    return last_sample;
		endcase
	endfunction

	// drain, then hold off long enough for a request with no result to finish
	task automatic settle_and_write(logic [CFG_W-1:0] value);
		@(negedge clk);
		in_valid <= 1'b0;
		while (medians.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		medians.set_window(value);
	endtask

	initial begin : result_sink
		int unsigned hold;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = steady ? 0 : $urandom_range(0, 3);
			if (hold != 0) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
			medians.check_result(median_twice);
		end
	end

	initial begin : stimulus
		int unsigned sizes [NUM_PHASES] = '{127, 1, 2, 3, 4, 5, 6, 7, 8, 9, 12, 16,
		                                    2, 64, 3, 5, 100, 33, 4, 0, 65, 3, 11, 2};
		int unsigned p;
		int unsigned n;
		int unsigned k;
		int unsigned count;
		logic restart;
		medians           = new();
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		in_valid          = 1'b0;
		sample            = '0;
		start_of_sequence = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset window of three: extremes and ties at both ends
		send_request(SAMPLE_MIN, 1'b1);
		send_request(SAMPLE_MAX, 1'b0);
		send_request(0, 1'b0);
		send_request(-1, 1'b0);
		send_request(SAMPLE_MAX, 1'b0);
		send_request(SAMPLE_MAX, 1'b0);
		send_request(SAMPLE_MIN, 1'b0);
		send_request(SAMPLE_MIN, 1'b0);
		send_request(SAMPLE_MIN, 1'b0);
		// restart mid-stream: window refills before any median
		send_request(5, 1'b1);
		send_request(6, 1'b0);
		send_request(7, 1'b0);

		// even window: sum of the two middle samples
		settle_and_write(CFG_W'(2));
		send_request(SAMPLE_MAX, 1'b1);
		send_request(SAMPLE_MAX, 1'b0);
		send_request(SAMPLE_MIN, 1'b0);
		send_request(SAMPLE_MIN, 1'b0);

		// zero size acts as one
		settle_and_write(CFG_W'(0));
		send_request(1, 1'b1);
		send_request(-7, 1'b0);

		// random phases; a phase that opens without restart resizes mid-sequence
		for (p = 0; p < NUM_PHASES; p++) begin
			settle_and_write(CFG_W'(sizes[p]));
			steady = ($urandom_range(0, 3) == 0);
			k = (sizes[p] == 0) ? 1 : (sizes[p] > WINDOW_MAX_DEF ? WINDOW_MAX_DEF : sizes[p]);
			count = (k > 16) ? 90 : 34;
			for (n = 0; n < count; n++) begin
				if (n == 0)
					restart = $urandom_range(0, 1);
				else
					restart = ($urandom_range(0, (k > 16) ? 199 : 11) == 0);
				send_request(pick_sample(), restart);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (medians.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!medians.failed() && medians.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
